### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of the deque engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define CDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs during reset.
`define CDE_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/cde_pkg.sv
// Shared constants, types and codes of the circular deque engine.
package cde_pkg;

  localparam int DEPTH      = 1024;   // power of two: slot arithmetic wraps naturally
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int DATA_W     = 32;
  localparam int POS_W      = 11;
  localparam int FUNC_W     = 3;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 112;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] word_t;
  typedef logic [POS_W-1:0]  pos_t;

  localparam cnt_t DEPTH_CNT = CNT_W'(DEPTH);

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_READ_AT    = 3'd4,
    FN_CLEAR      = 3'd5,
    FN_FILL       = 3'd6
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_FILL,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RT_NONE,
    RT_FRONT,
    RT_BACK,
    RT_READ
  } rd_tgt_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    word_t   front_value;
    word_t   back_value;
    word_t   read_value;
    cnt_t    occupancy;
    logic    is_empty;
    status_t status;
  } result_t;

endpackage

### rtl/core/cde_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module cde_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/cde_ctrl.sv
// Operation sequencer: head, count, cached end entries and store access.
module cde_ctrl import cde_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  func_t    func,
  input  word_t    value,
  input  pos_t     position,
  output mem_req_t mem_req,
  input  word_t    rd_data,
  output logic     res_valid,
  input  logic     res_ready,
  output result_t  res
);

  state_t  state_r, state_nxt;
  addr_t   head_r, head_nxt;
  cnt_t    count_r, count_nxt;
  word_t   front_r, front_nxt;
  word_t   back_r, back_nxt;
  word_t   rdval_r, rdval_nxt;
  status_t status_r, status_nxt;
  rd_tgt_t tgt_r, tgt_nxt;
  cnt_t    fill_idx_r, fill_idx_nxt;
  logic    empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r    <= front_nxt;
    back_r     <= back_nxt;
    rdval_r    <= rdval_nxt;
    status_r   <= status_nxt;
    tgt_r      <= tgt_nxt;
    fill_idx_r <= fill_idx_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    front_nxt    = front_r;
    back_nxt     = back_r;
    rdval_nxt    = rdval_r;
    status_nxt   = status_r;
    tgt_nxt      = tgt_r;
    fill_idx_nxt = fill_idx_r;
    mem_req      = '0;
    in_ready     = (state_r == S_IDLE);
    res_valid    = (state_r == S_DONE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = ST_OK;
          rdval_nxt  = '0;
          tgt_nxt    = RT_NONE;
          state_nxt  = S_DONE;
          case (func)
            FN_PUSH_FRONT: begin
              if (count_r == DEPTH_CNT) begin
                status_nxt = ST_FULL;
              end else begin
                head_nxt      = head_r - ADDR_W'(1);
                count_nxt     = count_r + CNT_W'(1);
                mem_req.we    = 1'b1;
                mem_req.waddr = head_r - ADDR_W'(1);
                mem_req.wdata = value;
                front_nxt     = value;
                if (count_r == '0) begin
                  back_nxt = value;
                end
              end
            end
            FN_PUSH_BACK: begin
              if (count_r == DEPTH_CNT) begin
                status_nxt = ST_FULL;
              end else begin
                count_nxt     = count_r + CNT_W'(1);
                mem_req.we    = 1'b1;
                mem_req.waddr = head_r + count_r[ADDR_W-1:0];
                mem_req.wdata = value;
                back_nxt      = value;
                if (count_r == '0) begin
                  front_nxt = value;
                end
              end
            end
            FN_POP_FRONT: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                head_nxt  = head_r + ADDR_W'(1);
                count_nxt = count_r - CNT_W'(1);
                if (count_r == CNT_W'(2)) begin
                  front_nxt = back_r;
                end else if (count_r > CNT_W'(2)) begin
                  mem_req.re    = 1'b1;
                  mem_req.raddr = head_r + ADDR_W'(1);
                  tgt_nxt       = RT_FRONT;
                  state_nxt     = S_READ;
                end
              end
            end
            FN_POP_BACK: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                if (count_r == CNT_W'(2)) begin
                  back_nxt = front_r;
                end else if (count_r > CNT_W'(2)) begin
                  mem_req.re    = 1'b1;
                  mem_req.raddr = head_r + ADDR_W'(count_r - CNT_W'(2));
                  tgt_nxt       = RT_BACK;
                  state_nxt     = S_READ;
                end
              end
            end
            FN_READ_AT: begin
              if (position >= count_r) begin
                status_nxt = ST_RANGE;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = head_r + position[ADDR_W-1:0];
                tgt_nxt       = RT_READ;
                state_nxt     = S_READ;
              end
            end
            FN_CLEAR: begin
              head_nxt  = '0;
              count_nxt = '0;
            end
            FN_FILL: begin
              if (position > DEPTH_CNT) begin
                status_nxt = ST_RANGE;
              end else begin
                head_nxt     = '0;
                count_nxt    = position;
                front_nxt    = value;
                back_nxt     = value;
                fill_idx_nxt = '0;
                if (position != '0) begin
                  state_nxt = S_FILL;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        case (tgt_r)
          RT_FRONT: front_nxt = rd_data;
          RT_BACK:  back_nxt  = rd_data;
          RT_READ:  rdval_nxt = rd_data;
          default:  begin
          end
        endcase
        state_nxt = S_DONE;
      end
      S_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = fill_idx_r[ADDR_W-1:0];
        mem_req.wdata = front_r;
        fill_idx_nxt  = fill_idx_r + CNT_W'(1);
        if (fill_idx_r == count_r - CNT_W'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign empty = (count_r == '0);

  always_comb begin
    res.front_value = empty ? '0 : front_r;
    res.back_value  = empty ? '0 : back_r;
    res.read_value  = rdval_r;
    res.occupancy   = count_r;
    res.is_empty    = empty;
    res.status      = status_r;
  end

endmodule

### rtl/core/circular_deque_engine_core.sv
// Top level of the circular deque engine: sequencer, entry store and output register.
//
// A double-ended queue of DEPTH 32-bit entries held in a circular store.
// Each beat on the in_ channel carries one operation (push front/back, pop
// front/back, read at a position from the front, clear, fill) and produces
// exactly one result beat on the out_ channel with the front and back
// entries, the read value, the occupancy, an empty flag and a status code.
// Front and back entries are cached in registers, so every operation needs
// at most one read of the single-read-port store.
// Pushes, clear, rejected operations and pops that leave at most one entry
// go straight to the result; pops that need the new end entry from the store
// and read_at first wait for the store's registered read data; a fill first
// writes one store entry per cycle until count entries hold the value.
// The sequencer takes no new operation until its result has moved to the
// output register.
// The output register holds a finished result while the next input beat is
// taken. When the receiver stalls, the sequencer parks one further result
// and stops taking input until the output register frees up.
// Reset empties the queue (head and count go to zero) and drops any pending
// result; stored words are not cleared and are never read before written.
module circular_deque_engine_core import cde_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] value, [42:32] position, rest zero
  input  logic [FUNC_W-1:0]     in_tuser,   // [2:0] func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] front_value, [63:32] back_value,
                                            // [95:64] read_value, [106:96] occupancy,
                                            // [107] is_empty, rest zero
  output logic [STAT_W-1:0]     out_tuser   // [1:0] status
);

  mem_req_t mem_req;
  word_t    rd_data;
  logic     res_valid;
  logic     res_ready;
  result_t  res;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [STAT_W-1:0]     out_user_r, out_user_nxt;

  // The sequencer owns the queue pointers and drives the store directly.
  cde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .func      (func_t'(in_tuser)),
    .value     (in_tdata[DATA_W-1:0]),
    .position  (in_tdata[DATA_W +: POS_W]),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  cde_ram #(
    .DATA_W (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

  // The output register takes a new result whenever it is empty or its
  // current beat is leaving in this cycle.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {4'b0000, res.is_empty, res.occupancy, res.read_value,
                       res.back_value, res.front_value};
      out_user_nxt  = res.status;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### rtl/core/cde_sva.sv
// Port-level checker of the circular deque engine and its bind.
`include "assert_macros.svh"

module cde_sva import cde_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STAT_W-1:0]     out_tuser
);

  logic  o_empty;
  cnt_t  o_occ;
  word_t o_front;
  word_t o_back;
  word_t o_read;
  logic  o_blank;
  logic  o_err;

  assign o_front = out_tdata[31:0];
  assign o_back  = out_tdata[63:32];
  assign o_read  = out_tdata[95:64];
  assign o_occ   = out_tdata[106:96];
  assign o_empty = out_tdata[107];
  assign o_blank = (o_front == '0) && (o_back == '0);
  assign o_err   = out_tvalid && (out_tuser != ST_OK);

  `CDE_ASSERT_NR(a_idle_after_reset, !rst_n |=> !out_tvalid, "result valid after reset")
  `CDE_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `CDE_ASSERT(a_empty_flag, out_tvalid |-> (o_empty == (o_occ == '0)), "empty flag disagrees")
  `CDE_ASSERT(a_empty_ends, out_tvalid && o_empty |-> o_blank, "empty ends nonzero")
  `CDE_ASSERT(a_err_no_read, o_err |-> o_read == '0 && o_occ <= DEPTH_CNT, "error result carries data")

endmodule

bind circular_deque_engine_core cde_sva u_cde_sva (.*);
